// ===== rtl/tgr_pkg.sv =====
// Shared types and constants for the touch gesture recognizer.
// No dependencies; every other file in rtl/ imports this package.
package tgr_pkg;

    // Per-slot gesture phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_LONG    = 2'd2,
        PH_DRAG    = 2'd3
    } phase_t;

    // Event codes as seen on event_kind
    typedef enum logic [2:0] {
        EV_DOWN       = 3'd0,
        EV_UP         = 3'd1,
        EV_CLICK      = 3'd2,
        EV_DOUBLE     = 3'd3,
        EV_LONG       = 3'd4,
        EV_DRAG_START = 3'd5,
        EV_DRAG_MOVE  = 3'd6,
        EV_DRAG_END   = 3'd7
    } evt_kind_t;

    // Configuration register indexes
    localparam logic [1:0] REG_CLICK_MAX  = 2'd0;
    localparam logic [1:0] REG_DBL_WIN    = 2'd1;
    localparam logic [1:0] REG_DRAG_DIST  = 2'd2;
    localparam logic [1:0] REG_LONG_TIME  = 2'd3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SLOT_W     = 2;

    // Output queue: up to two pushes and one pop per cycle
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef struct packed {
        logic [15:0] click_max;
        logic [15:0] dbl_win;
        logic [13:0] drag_dist;
        logic [15:0] long_time;
    } cfg_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               pressed;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        stamp;
    } sample_t;

    typedef struct packed {
        phase_t             phase;
        logic [31:0]        press_start;
        logic signed [15:0] press_px;
        logic signed [15:0] press_py;
        logic               long_done;
        logic               drag_begun;
        logic [31:0]        click_stamp;
        logic signed [15:0] click_px;
        logic signed [15:0] click_py;
    } slot_state_t;

    typedef struct packed {
        evt_kind_t          kind;
        logic [SLOT_W-1:0]  slot;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        stamp;
        logic               primary;
        logic               last;
    } evt_t;

    // Full-width Manhattan distance between two signed 16-bit points
    function automatic logic [16:0] manhattan(
        input logic signed [15:0] ax,
        input logic signed [15:0] ay,
        input logic signed [15:0] bx,
        input logic signed [15:0] by
    );
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [16:0]        mx;
        logic [16:0]        my;
        dx = {ax[15], ax} - {bx[15], bx};
        dy = {ay[15], ay} - {by[15], by};
        mx = dx[16] ? 17'(-dx) : 17'(dx);
        my = dy[16] ? 17'(-dy) : 17'(dy);
        return {1'b0, mx[15:0]} + {1'b0, my[15:0]};
    endfunction

endpackage

// ===== rtl/tgr_engine.sv =====
// Gesture decision logic for one sample against its slot's state.
// Combinational; depends on tgr_pkg.
module tgr_engine (
    input  tgr_pkg::cfg_t        cfg,
    input  tgr_pkg::sample_t     smp,
    input  tgr_pkg::slot_state_t cur,
    output tgr_pkg::slot_state_t nxt,
    output tgr_pkg::evt_t        ev0,
    output tgr_pkg::evt_t        ev1,
    output logic [1:0]           n_ev
);
    import tgr_pkg::*;

    logic [31:0] held;
    logic [31:0] since_click;
    logic [16:0] dist_press;
    logic [16:0] dist_click;
    logic        was_idle;
    logic        long_hit;
    logic        dbl_hit;
    logic signed [15:0] eff_px;
    logic signed [15:0] eff_py;
    evt_kind_t   k0;
    evt_kind_t   k1;

    // Time and distance terms, all wrapping modulo 2^32 for time
    assign held        = smp.stamp - cur.press_start;
    assign since_click = smp.stamp - cur.click_stamp;
    assign dist_press  = manhattan(smp.x, smp.y, cur.press_px, cur.press_py);
    assign dist_click  = manhattan(smp.x, smp.y, cur.click_px, cur.click_py);
    assign was_idle    = (cur.phase == PH_IDLE);

    // A fresh press has zero hold time
    assign long_hit = was_idle ? (cfg.long_time == 16'd0)
                               : (held >= {16'd0, cfg.long_time});
    assign dbl_hit  = (cur.click_stamp != 32'd0)
                   && (since_click <= {16'd0, cfg.dbl_win})
                   && (dist_click <= {2'b00, cfg.drag_dist, 1'b0});
    assign eff_px   = was_idle ? smp.x : cur.press_px;
    assign eff_py   = was_idle ? smp.y : cur.press_py;

    // Next state and up to two event kinds
    always_comb
    begin
        nxt  = cur;
        n_ev = 2'd0;
        k0   = EV_DOWN;
        k1   = EV_DOWN;
        if (smp.pressed)
        begin
            if (was_idle)
            begin
                nxt.phase       = PH_PRESSED;
                nxt.press_start = smp.stamp;
                nxt.press_px    = smp.x;
                nxt.press_py    = smp.y;
                nxt.long_done   = 1'b0;
                nxt.drag_begun  = 1'b0;
                k0   = EV_DOWN;
                n_ev = 2'd1;
            end
            else if (!cur.drag_begun && dist_press >= {3'b000, cfg.drag_dist})
            begin
                nxt.drag_begun = 1'b1;
                nxt.phase      = PH_DRAG;
                k0   = EV_DRAG_START;
                n_ev = 2'd1;
            end
            else if (cur.phase == PH_DRAG)
            begin
                k0   = EV_DRAG_MOVE;
                n_ev = 2'd1;
            end
            // Long press check runs on the updated phase
            if (nxt.phase == PH_PRESSED && !nxt.long_done && long_hit)
            begin
                nxt.long_done = 1'b1;
                nxt.phase     = PH_LONG;
                if (n_ev == 2'd0)
                begin
                    k0   = EV_LONG;
                    n_ev = 2'd1;
                end
                else
                begin
                    k1   = EV_LONG;
                    n_ev = 2'd2;
                end
            end
        end
        else if (!was_idle)
        begin
            if (cur.phase == PH_DRAG)
            begin
                k0   = EV_DRAG_END;
                n_ev = 2'd1;
            end
            else
            begin
                k0   = EV_UP;
                n_ev = 2'd1;
                if (!cur.long_done && held <= {16'd0, cfg.click_max})
                begin
                    n_ev = 2'd2;
                    if (dbl_hit)
                    begin
                        k1 = EV_DOUBLE;
                        nxt.click_stamp = 32'd0;
                    end
                    else
                    begin
                        k1 = EV_CLICK;
                        nxt.click_stamp = smp.stamp;
                        nxt.click_px    = smp.x;
                        nxt.click_py    = smp.y;
                    end
                end
            end
            nxt.phase       = PH_IDLE;
            nxt.press_start = 32'd0;
        end
    end

    // Build event beats; a long press reports the press position
    always_comb
    begin
        ev0.kind    = k0;
        ev0.slot    = smp.slot;
        ev0.x       = (k0 == EV_LONG) ? eff_px : smp.x;
        ev0.y       = (k0 == EV_LONG) ? eff_py : smp.y;
        ev0.stamp   = smp.stamp;
        ev0.primary = k0 inside {EV_DOWN, EV_CLICK, EV_DOUBLE, EV_LONG};
        ev0.last    = (n_ev == 2'd1);
        ev1.kind    = k1;
        ev1.slot    = smp.slot;
        ev1.x       = (k1 == EV_LONG) ? eff_px : smp.x;
        ev1.y       = (k1 == EV_LONG) ? eff_py : smp.y;
        ev1.stamp   = smp.stamp;
        ev1.primary = k1 inside {EV_DOWN, EV_CLICK, EV_DOUBLE, EV_LONG};
        ev1.last    = 1'b1;
    end

endmodule

// ===== rtl/tgr_evt_queue.sv =====
// Output event queue: up to two beats pushed, one beat popped per cycle.
// Depends on tgr_pkg.
module tgr_evt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_n,
    input  tgr_pkg::evt_t push0,
    input  tgr_pkg::evt_t push1,
    input  logic          pop,
    output tgr_pkg::evt_t head,
    output logic          not_empty,
    output logic          room
);
    import tgr_pkg::*;

    evt_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg;
    logic [Q_PTR_W:0]   count_next;
    logic               do_pop;

    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= (Q_PTR_W+1)'(Q_DEPTH - 2));
    assign head      = mem[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(do_pop);
        count_next  = count_reg + (Q_PTR_W+1)'(push_n) - (Q_PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed beats
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_reg + Q_PTR_W'(1)] <= push1;
        end
    end

endmodule

// ===== rtl/touch_gesture_recognizer.sv =====
// Touch gesture recognizer: one touch sample in, zero to two gesture event beats out.
// Depends on tgr_pkg, tgr_engine and tgr_evt_queue.
//
// Each accepted sample lands in an input register; once the output queue has room for two
// events, its slot's state is read, the gesture decision is made and up to two events are
// written into a four-entry output queue, whose head drives the output. A sample is taken every
// cycle while the queue holds at most two events; the single output port drains one event per
// cycle while out_ready is high, so a stream of samples that give two events each fills the
// queue faster than it drains and holds off new samples. Only slots 0..3 are reachable through
// the 2-bit slot field; a slot at or above SLOT_COUNT is dropped without events. Configuration
// registers must be written while no sample is in flight.
module touch_gesture_recognizer #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tgr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [tgr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tgr_pkg::SLOT_W-1:0]      slot,
    input  logic                            pressed,
    input  logic signed [15:0]              pos_x,
    input  logic signed [15:0]              pos_y,
    input  logic [31:0]                     stamp,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      event_kind,
    output logic [tgr_pkg::SLOT_W-1:0]      event_slot,
    output logic signed [15:0]              event_x,
    output logic signed [15:0]              event_y,
    output logic [31:0]                     event_time,
    output logic                            primary,
    output logic                            last_of_run
);
    import tgr_pkg::*;

    localparam int SLOTS_USED = (SLOT_COUNT < (1 << SLOT_W)) ? SLOT_COUNT : (1 << SLOT_W);
    localparam int IDX_W      = (SLOTS_USED > 1) ? $clog2(SLOTS_USED) : 1;

    cfg_t        cfg_reg;
    logic        iv_reg;
    sample_t     smp_reg;
    slot_state_t st_reg [SLOTS_USED];
    slot_state_t cur;
    slot_state_t nxt;
    evt_t        ev0;
    evt_t        ev1;
    evt_t        head;
    logic [1:0]  n_ev;
    logic [1:0]  push_n;
    logic        room;
    logic        go;
    logic        slot_ok;
    logic [IDX_W-1:0] idx;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.click_max <= 16'd300;
            cfg_reg.dbl_win   <= 16'd300;
            cfg_reg.drag_dist <= 14'd10;
            cfg_reg.long_time <= 16'd800;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_CLICK_MAX: cfg_reg.click_max <= cfg_wdata;
                REG_DBL_WIN:   cfg_reg.dbl_win   <= cfg_wdata;
                REG_DRAG_DIST: cfg_reg.drag_dist <= cfg_wdata[13:0];
                REG_LONG_TIME: cfg_reg.long_time <= cfg_wdata;
                default:       cfg_reg.click_max <= cfg_reg.click_max;
            endcase
        end
    end

    // Process the held sample when the queue can take two beats
    assign go       = iv_reg && room;
    assign in_ready = !iv_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            iv_reg <= 1'b1;
        end
        else if (go)
        begin
            iv_reg <= 1'b0;
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            smp_reg.slot    <= slot;
            smp_reg.pressed <= pressed;
            smp_reg.x       <= pos_x;
            smp_reg.y       <= pos_y;
            smp_reg.stamp   <= stamp;
        end
    end

    // Select the slot's state; drop slots beyond the configured count
    assign slot_ok = ({1'b0, smp_reg.slot} < (SLOT_W+1)'(SLOTS_USED));
    assign idx     = slot_ok ? smp_reg.slot[IDX_W-1:0] : '0;
    assign cur     = st_reg[idx];

    tgr_engine u_engine (
        .cfg  (cfg_reg),
        .smp  (smp_reg),
        .cur  (cur),
        .nxt  (nxt),
        .ev0  (ev0),
        .ev1  (ev1),
        .n_ev (n_ev)
    );

    // Update slot state on a processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS_USED; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else if (go && slot_ok)
        begin
            st_reg[idx] <= nxt;
        end
    end

    assign push_n = (go && slot_ok) ? n_ev : 2'd0;

    tgr_evt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push0     (ev0),
        .push1     (ev1),
        .pop       (out_ready),
        .head      (head),
        .not_empty (out_valid),
        .room      (room)
    );

    // Drive the output beat from the queue head
    assign event_kind  = head.kind;
    assign event_slot  = head.slot;
    assign event_x     = head.x;
    assign event_y     = head.y;
    assign event_time  = head.stamp;
    assign primary     = head.primary;
    assign last_of_run = head.last;

endmodule

// ===== rtl/tgr_checker.sv =====
// Port-level checks for the touch gesture recognizer, bound to the top level.
// Depends on tgr_pkg and touch_gesture_recognizer.
module tgr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [2:0]                  event_kind,
    input logic [tgr_pkg::SLOT_W-1:0]  event_slot,
    input logic signed [15:0]          event_x,
    input logic signed [15:0]          event_y,
    input logic [31:0]                 event_time,
    input logic                        primary,
    input logic                        last_of_run
);
    import tgr_pkg::*;

    // Hold a stalled output beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind)
            && $stable(event_x) && $stable(event_y) && $stable(event_time)
            && $stable(last_of_run))
        else $error("stalled output beat changed");

    // Primary flag follows the event kind
    a_primary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> primary == (event_kind == EV_DOWN || event_kind == EV_CLICK
            || event_kind == EV_DOUBLE || event_kind == EV_LONG))
        else $error("primary flag does not match event kind");

    // Only a down or an up can open a two-event run
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> event_kind == EV_DOWN || event_kind == EV_UP)
        else $error("unexpected non-final event kind");

    // The second beat of a run follows at once with the same slot and time
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid && last_of_run
            && event_slot == $past(event_slot) && event_time == $past(event_time))
        else $error("second event of a run missing or mismatched");

endmodule

bind touch_gesture_recognizer tgr_checker u_tgr_checker (.*);

// ===== tb/touch_gesture_recognizer_test.sv =====
// Self-checking testbench for touch_gesture_recognizer: directed and random touch samples,
// predicted events checked beat by beat. Depends on tgr_pkg and the RTL under rtl/.
module touch_gesture_recognizer_test;
    import tgr_pkg::*;

    localparam int SLOTS        = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LATENCY_PAD  = 8;
    localparam int CHOKE_CYCLES = 300;
    localparam int MAX_REPORTS  = 10;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    in_valid  = 1'b0;
    logic [SLOT_W-1:0]       slot      = '0;
    logic                    pressed   = 1'b0;
    logic signed [15:0]      pos_x     = '0;
    logic signed [15:0]      pos_y     = '0;
    logic [31:0]             stamp     = '0;
    logic                    out_ready = 1'b0;
    logic                    in_ready;
    logic                    out_valid;
    logic [2:0]              event_kind;
    logic [SLOT_W-1:0]       event_slot;
    logic signed [15:0]      event_x;
    logic signed [15:0]      event_y;
    logic [31:0]             event_time;
    logic                    primary;
    logic                    last_of_run;

    // Gesture model: configuration and per-slot state
    logic [15:0]             cfg_tap_max;
    logic [15:0]             cfg_dbl_gap;
    logic [13:0]             cfg_drag_dist;
    logic [15:0]             cfg_hold_time;
    phase_t                  touch_phase [SLOTS];
    logic [31:0]             touch_t0    [SLOTS];
    logic signed [15:0]      touch_x0    [SLOTS];
    logic signed [15:0]      touch_y0    [SLOTS];
    logic                    long_fired  [SLOTS];
    logic                    drag_on     [SLOTS];
    logic [31:0]             tap_stamp   [SLOTS];
    logic signed [15:0]      tap_x       [SLOTS];
    logic signed [15:0]      tap_y       [SLOTS];

    evt_t                    due_events [$];
    int unsigned             mismatches  = 0;
    int unsigned             cycle_count = 0;

    // Stimulus control shared with the sink process
    bit                      src_gaps  = 1'b1;
    bit                      sink_gaps = 1'b1;
    bit                      choke_req = 1'b0;

    // Random gesture generator state
    logic [31:0]             clock_ticks = 32'd100000;
    int                      last_slot   = 0;
    logic                    held  [SLOTS] = '{default: 1'b0};
    logic signed [15:0]      cur_x [SLOTS] = '{default: 16'sd0};
    logic signed [15:0]      cur_y [SLOTS] = '{default: 16'sd0};

    touch_gesture_recognizer #(
        .SLOT_COUNT (SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .slot        (slot),
        .pressed     (pressed),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .stamp       (stamp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .event_slot  (event_slot),
        .event_x     (event_x),
        .event_y     (event_y),
        .event_time  (event_time),
        .primary     (primary),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Abort a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Full-width Manhattan distance, no 16-bit wrap
    function automatic int unsigned taxicab(input logic signed [15:0] ax, ay, bx, by);
        int dx;
        int dy;
        dx = int'(ax) - int'(bx);
        dy = int'(ay) - int'(by);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return dx + dy;
    endfunction

    function automatic evt_t make_evt(input evt_kind_t k, input logic [1:0] s,
                                      input logic signed [15:0] x, y,
                                      input logic [31:0] t, input logic prim);
        evt_t e;
        e.kind    = k;
        e.slot    = s;
        e.x       = x;
        e.y       = y;
        e.stamp   = t;
        e.primary = prim;
        e.last    = 1'b0;
        return e;
    endfunction

    // Advance the gesture model by one sample and queue the events it causes
    function automatic void predict_sample(input logic [1:0] s, input logic down,
                                           input logic signed [15:0] x, y,
                                           input logic [31:0] t);
        evt_t        ev [2];
        int          n;
        logic [31:0] held_for;
        logic [31:0] since_tap;
        n = 0;
        if (int'(s) >= SLOTS) return;
        if (down) begin
            if (touch_phase[s] == PH_IDLE) begin
                touch_phase[s] = PH_PRESSED;
                touch_t0[s]    = t;
                touch_x0[s]    = x;
                touch_y0[s]    = y;
                long_fired[s]  = 1'b0;
                drag_on[s]     = 1'b0;
                ev[n] = make_evt(EV_DOWN, s, x, y, t, 1'b1);
                n++;
            end
            else if (!drag_on[s] &&
                     taxicab(x, y, touch_x0[s], touch_y0[s]) >= cfg_drag_dist) begin
                drag_on[s]     = 1'b1;
                touch_phase[s] = PH_DRAG;
                ev[n] = make_evt(EV_DRAG_START, s, x, y, t, 1'b0);
                n++;
            end
            else if (touch_phase[s] == PH_DRAG) begin
                ev[n] = make_evt(EV_DRAG_MOVE, s, x, y, t, 1'b0);
                n++;
            end
            // Fire the long press once, reported at the press position
            held_for = t - touch_t0[s];
            if (touch_phase[s] == PH_PRESSED && !long_fired[s] &&
                held_for >= 32'(cfg_hold_time)) begin
                long_fired[s]  = 1'b1;
                touch_phase[s] = PH_LONG;
                ev[n] = make_evt(EV_LONG, s, touch_x0[s], touch_y0[s], t, 1'b1);
                n++;
            end
        end
        else if (touch_phase[s] != PH_IDLE) begin
            held_for = t - touch_t0[s];
            if (touch_phase[s] == PH_DRAG) begin
                ev[n] = make_evt(EV_DRAG_END, s, x, y, t, 1'b0);
                n++;
            end
            else begin
                ev[n] = make_evt(EV_UP, s, x, y, t, 1'b0);
                n++;
                if (!long_fired[s] && held_for <= 32'(cfg_tap_max)) begin
                    since_tap = t - tap_stamp[s];
                    // A zero tap stamp means no earlier click is pending
                    if (tap_stamp[s] != 32'd0 && since_tap <= 32'(cfg_dbl_gap) &&
                        taxicab(x, y, tap_x[s], tap_y[s]) <= 32'({cfg_drag_dist, 1'b0})) begin
                        ev[n] = make_evt(EV_DOUBLE, s, x, y, t, 1'b1);
                        n++;
                        tap_stamp[s] = 32'd0;
                    end
                    else begin
                        ev[n] = make_evt(EV_CLICK, s, x, y, t, 1'b1);
                        n++;
                        tap_stamp[s] = t;
                        tap_x[s]     = x;
                        tap_y[s]     = y;
                    end
                end
            end
            touch_phase[s] = PH_IDLE;
            touch_t0[s]    = 32'd0;
        end
        for (int i = 0; i < n; i++) begin
            ev[i].last = (i == n - 1);
            due_events.push_back(ev[i]);
        end
    endfunction

    function automatic string describe(input evt_t e);
        return $sformatf("%s slot=%0d x=%0d y=%0d t=%h prim=%b last=%b",
                         e.kind.name(), e.slot, e.x, e.y, e.stamp, e.primary, e.last);
    endfunction

    task automatic report_event(input string why, input string want_txt, input evt_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected %s, got %s", $realtime, why, want_txt, describe(got));
    endtask

    // Track config writes and accepted samples; check every output beat
    always @(posedge clk)
    begin
        evt_t got;
        evt_t want;
        if (!rst_n) begin
            cfg_tap_max   = 16'd300;
            cfg_dbl_gap   = 16'd300;
            cfg_drag_dist = 14'd10;
            cfg_hold_time = 16'd800;
            for (int i = 0; i < SLOTS; i++) begin
                touch_phase[i] = PH_IDLE;
                touch_t0[i]    = '0;
                touch_x0[i]    = '0;
                touch_y0[i]    = '0;
                long_fired[i]  = 1'b0;
                drag_on[i]     = 1'b0;
                tap_stamp[i]   = '0;
                tap_x[i]       = '0;
                tap_y[i]       = '0;
            end
            due_events.delete();
        end
        else begin
            if (out_valid && out_ready) begin
                got.kind    = evt_kind_t'(event_kind);
                got.slot    = event_slot;
                got.x       = event_x;
                got.y       = event_y;
                got.stamp   = event_time;
                got.primary = primary;
                got.last    = last_of_run;
                if (due_events.size() == 0)
                    report_event("unexpected event", "none", got);
                else begin
                    want = due_events.pop_front();
                    if (got.kind !== want.kind || got.slot !== want.slot ||
                        got.x !== want.x || got.y !== want.y ||
                        got.stamp !== want.stamp || got.primary !== want.primary ||
                        got.last !== want.last)
                        report_event("event mismatch", describe(want), got);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_CLICK_MAX: cfg_tap_max   = cfg_wdata;
                    REG_DBL_WIN:   cfg_dbl_gap   = cfg_wdata;
                    REG_DRAG_DIST: cfg_drag_dist = cfg_wdata[13:0];
                    REG_LONG_TIME: cfg_hold_time = cfg_wdata;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_sample(slot, pressed, pos_x, pos_y, stamp);
        end
    end

    // Event sink: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (choke_req) begin
                out_ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge clk);
                choke_req = 1'b0;
            end
            gap = sink_gaps ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid && !choke_req);
            @(posedge clk);
        end
    end

    // Offer one sample and hold it until the beat is taken
    task automatic send_sample(input logic [1:0] s, input logic down,
                               input logic signed [15:0] x, y, input logic [31:0] t);
        int gap;
        gap = src_gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        slot     <= s;
        pressed  <= down;
        pos_x    <= x;
        pos_y    <= y;
        stamp    <= t;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    // Drop valid, wait for every predicted event, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_events.size() != 0) @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] tap_max, dbl_gap, drag, hold);
        write_reg(REG_CLICK_MAX, tap_max);
        write_reg(REG_DBL_WIN, dbl_gap);
        write_reg(REG_DRAG_DIST, drag);
        write_reg(REG_LONG_TIME, hold);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_ticks();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r < 5) return 16'($urandom_range(1, 40));
        return 16'($urandom_range(50, 1500));
    endfunction

    // Upper bits beyond 14 are written too, so truncation gets exercised
    function automatic logic [15:0] pick_radius();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r == 2) return 16'($urandom);
        return 16'($urandom_range(1, 40));
    endfunction

    // Time between samples, scaled to the current thresholds
    function automatic logic [31:0] tick_step();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 8) return $urandom_range(0, cfg_tap_max / 4 + 8);
        if (r < 12) return $urandom_range(0, cfg_hold_time + 50);
        if (r < 14) return $urandom_range(0, 3 * cfg_hold_time + 200);
        if (r == 14) return $urandom_range(0, 200000);
        return $urandom;
    endfunction

    function automatic logic signed [15:0] nudge(input logic signed [15:0] v, input int reach);
        int d;
        d = int'($urandom_range(0, 2 * reach)) - reach;
        return v + 16'(d);
    endfunction

    // Taps, double tap, long press, drag, stray release, extremes and stamp wrap
    task automatic test_basic_gestures();
        send_sample(2'd0, 1'b1, 100, 100, 32'd1000);
        send_sample(2'd0, 1'b0, 100, 100, 32'd1100);
        send_sample(2'd0, 1'b1, 104, 98, 32'd1200);
        send_sample(2'd0, 1'b0, 105, 103, 32'd1250);
        send_sample(2'd1, 1'b0, 7, 7, 32'd1300);
        send_sample(2'd1, 1'b1, 0, 0, 32'd2000);
        send_sample(2'd1, 1'b1, 3, 3, 32'd2100);
        send_sample(2'd1, 1'b1, 1, 1, 32'd2800);
        send_sample(2'd1, 1'b1, 20, 0, 32'd2900);
        send_sample(2'd1, 1'b1, 30, 5, 32'd2950);
        send_sample(2'd1, 1'b0, 31, 5, 32'd3000);
        send_sample(2'd2, 1'b1, 16'sh8000, 16'sh8000, 32'hFFFF_FF00);
        send_sample(2'd2, 1'b1, 16'sh7FFF, 16'sh7FFF, 32'h0000_0010);
        send_sample(2'd2, 1'b0, 16'sh7FFF, 16'sh7FFF, 32'h0000_0020);
        send_sample(2'd3, 1'b1, 16'sh7FFF, 16'sh8000, 32'hFFFF_FFF0);
        send_sample(2'd3, 1'b0, 16'sh7FFF, 16'sh8000, 32'h0000_0000);
        send_sample(2'd3, 1'b1, 16'sh7FFF, 16'sh8000, 32'd100);
        send_sample(2'd3, 1'b0, 16'sh7FFF, 16'sh8000, 32'd150);
        send_sample(2'd0, 1'b1, 0, 0, 32'd5000);
        send_sample(2'd0, 1'b0, 0, 0, 32'd5400);
        settle();
    endtask

    // Zero thresholds and all-ones registers
    task automatic test_register_corners();
        program_regs(16'd300, 16'd300, 16'd10, 16'd0);
        send_sample(2'd0, 1'b1, 50, 50, 32'd6000);
        send_sample(2'd0, 1'b0, 50, 50, 32'd6100);
        settle();
        program_regs(16'd0, 16'd0, 16'd0, 16'd800);
        send_sample(2'd2, 1'b1, -5, 9, 32'd7000);
        send_sample(2'd2, 1'b0, -5, 9, 32'd7000);
        send_sample(2'd2, 1'b1, -5, 9, 32'd7000);
        send_sample(2'd2, 1'b0, -5, 9, 32'd7000);
        settle();
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(2'd3, 1'b1, 16'sh8000, 16'sh8000, 32'd10);
        send_sample(2'd3, 1'b0, 16'sh7FFF, 16'sh7FFF, 32'd65545);
        settle();
    endtask

    // Well-formed press/move/release runs with random content, plus stray releases
    task automatic test_random_gestures(input int items, input bit src_on,
                                        input bit sink_on, input bit use_defaults);
        logic [1:0] s;
        int         reach;
        if (use_defaults)
            program_regs(16'd300, 16'd300, 16'd10, 16'd800);
        else
            program_regs(pick_ticks(), pick_ticks(), pick_radius(), pick_ticks());
        src_gaps  = src_on;
        sink_gaps = sink_on;
        for (int n = 0; n < items; n++) begin
            // Mostly stay on one slot so gestures complete
            if ($urandom_range(0, 9) < 3) last_slot = $urandom_range(0, SLOTS - 1);
            s = last_slot[1:0];
            clock_ticks += tick_step();
            reach = ($urandom_range(0, 3) == 0) ? 60 : 6;
            if (!held[s]) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_sample(s, 1'b0, 16'($urandom), 16'($urandom), clock_ticks);
                    continue;
                end
                if ($urandom_range(0, 4) == 0) begin
                    cur_x[s] = 16'($urandom);
                    cur_y[s] = 16'($urandom);
                end
                else begin
                    cur_x[s] = nudge(cur_x[s], reach);
                    cur_y[s] = nudge(cur_y[s], reach);
                end
                held[s] = 1'b1;
                send_sample(s, 1'b1, cur_x[s], cur_y[s], clock_ticks);
            end
            else begin
                cur_x[s] = nudge(cur_x[s], reach);
                cur_y[s] = nudge(cur_y[s], reach);
                held[s]  = ($urandom_range(0, 9) >= 4);
                send_sample(s, held[s], cur_x[s], cur_y[s], clock_ticks);
            end
        end
        settle();
    endtask

    // Hold off the sink while samples keep coming, so the event queue backs up
    task automatic test_output_backpressure();
        logic [1:0] s;
        program_regs(16'd300, 16'd300, 16'd10, 16'd800);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        choke_req = 1'b1;
        for (int n = 0; n < 12; n++) begin
            s = 2'(n % SLOTS);
            clock_ticks += 32'd40;
            send_sample(s, 1'b1, cur_x[s], cur_y[s], clock_ticks);
            send_sample(s, 1'b0, cur_x[s], cur_y[s], clock_ticks + 32'd30);
            held[s] = 1'b0;
        end
        settle();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_gestures();
        test_register_corners();
        test_random_gestures(200, 1'b1, 1'b1, 1'b1);
        test_random_gestures(200, 1'b0, 1'b1, 1'b0);
        test_random_gestures(200, 1'b1, 1'b0, 1'b0);
        test_random_gestures(200, 1'b0, 1'b0, 1'b0);
        test_random_gestures(200, 1'b1, 1'b1, 1'b0);
        test_output_backpressure();
        if (mismatches == 0 && due_events.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tgr_pkg.sv
rtl/tgr_engine.sv
rtl/tgr_evt_queue.sv
rtl/touch_gesture_recognizer.sv
rtl/tgr_checker.sv
tb/touch_gesture_recognizer_test.sv
